/* rtl/triangular_symmetric_interchange_defines.svh */
// Assertion macros shared by the triangle interchange RTL.
// Every macro expects a clock named clock and an active-high reset named reset.
`ifndef TRIANGULAR_SYMMETRIC_INTERCHANGE_DEFINES_SVH
`define TRIANGULAR_SYMMETRIC_INTERCHANGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define TSI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TSI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tsi_pkg.sv */
// Shared types and codes for the triangle-stored matrix interchange block.
// No dependencies; used by tsi_op_unit and triangular_symmetric_interchange.
`default_nettype none

package tsi_pkg;

   // Field widths fixed by the request and response formats
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned IDX_W      = 6;
   localparam int unsigned VAL_W      = 32;
   localparam int unsigned ORD_W      = 7;
   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 7;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SWAP  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_TRIANGLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HERMITIAN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SKEW     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORDER    = 2'd3;

   localparam logic [ORD_W-1:0] ORDER_RESET = 7'd64;

   // Operation applied to a moved entry; code is {hermitian, skew}
   typedef enum logic [1:0] {
      OP_IDENT  = 2'd0,
      OP_NEG    = 2'd1,
      OP_CONJ   = 2'd2,
      OP_NEG_RE = 2'd3
   } op_type;

   // One complex Q16.16 entry, real part in the low half
   typedef struct packed {
      logic [VAL_W-1:0] im;
      logic [VAL_W-1:0] re;
   } cplx_type;

endpackage

`default_nettype wire

/* rtl/tsi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsi_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/tsi_op_unit.sv */
// Shared symmetry operation unit: identity, negate, conjugate or negate real part.
// Depends on tsi_pkg; all negations saturate at the most positive value.
`default_nettype none

module tsi_op_unit
   import tsi_pkg::*;
(
   input  wire op_type   op,
   input  wire cplx_type data_in,
   output cplx_type      data_out
);

   // Two's complement negation, most negative value maps to most positive
   function automatic logic [VAL_W-1:0] sat_neg(input logic [VAL_W-1:0] v);
      logic [VAL_W-1:0] min_val;
      min_val = {1'b1, {(VAL_W-1){1'b0}}};
      if (v == min_val) begin
         return ~min_val;
      end
      return ~v + {{(VAL_W-1){1'b0}}, 1'b1};
   endfunction

   always_comb begin
      data_out = data_in;
      unique case (op)
         OP_IDENT: begin
            data_out = data_in;
         end
         OP_NEG: begin
            data_out.re = sat_neg(data_in.re);
            data_out.im = sat_neg(data_in.im);
         end
         OP_CONJ: begin
            data_out.im = sat_neg(data_in.im);
         end
         OP_NEG_RE: begin
            data_out.re = sat_neg(data_in.re);
         end
         default: begin
            data_out = data_in;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/triangular_symmetric_interchange.sv */
// Triangle-stored complex matrix with symmetric row/column interchange.
// Depends on tsi_pkg, tsi_ram, tsi_op_unit and the assertion macro header.
// Requests come in on req_* (func in tuser), one response per request on rsp_*.
// Registers are written through csr_* with csr_we high; the user must write them
// only while idle, which the block does not enforce. A write request passes
// through decode and response states, a read also through a RAM wait state.
// An interchange walks n entry pairs through the RAM, each in read, read, write,
// write steps; one that changes nothing, or is rejected, answers like a write.
// One request is in work at a time: req_tready is high only when idle.
// The response sits in an output register; a new request is accepted while it
// waits, and the next response is held back until rsp_tready takes the old one.
// Reset clears the sequencer, the response valid and the configuration
// (lower triangle, transpose symmetry, n = 64); the matrix RAM is not cleared
// and must be loaded by write requests before it is read or interchanged.
`default_nettype none

`include "triangular_symmetric_interchange_defines.svh"

module triangular_symmetric_interchange
   import tsi_pkg::*;
#(
   parameter int unsigned MAX_ORDER = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: tdata = row[5:0], col[11:6], value_real[43:12], value_imag[75:44],
   //          first_index[82:76], second_index[89:83], zero pad [95:90]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [FUNC_W-1:0]     req_tuser,   // func[1:0]
   // response: tdata = read_real[31:0], read_imag[63:32]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [0:0]            rsp_tuser,   // status[0]
   // configuration writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned IW    = $clog2(MAX_ORDER);
   localparam int unsigned DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int unsigned ADW   = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(MAX_ORDER + 1);
   localparam int unsigned NW    = (CW > ORD_W) ? CW : ORD_W;
   localparam logic [NW-1:0] MAX_N = NW'(MAX_ORDER);
   localparam logic [NW-1:0] ONE_N = NW'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD_WAIT,
      S_RD_P,
      S_RD_Q,
      S_WR_P,
      S_WR_Q,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      PH_DIAG,
      PH_PRE,
      PH_KL,
      PH_MID,
      PH_POST
   } phase_type;

   // Configuration
   logic             tri_ff, herm_ff, skew_ff;
   logic [ORD_W-1:0] order_ff;

   // Sequencer and request holding
   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [IDX_W-1:0]   row_ff, row_in, col_ff, col_in;
   cplx_type           val_ff, val_in;
   logic [ORD_W-1:0]   k_ff, k_in, l_ff, l_in;
   logic [NW-1:0]      k0_ff, k0_in, l0_ff, l0_in, i_ff, i_in;
   cplx_type           hold_ff, hold_in;
   cplx_type           res_ff, res_in;
   logic               status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cplx_type           rsp_data_ff, rsp_data_in;
   logic               rsp_status_ff, rsp_status_in;

   // RAM and unit connections
   logic           ram_we, ram_re;
   logic [ADW-1:0] ram_waddr, ram_raddr;
   cplx_type       ram_wdata, ram_rdata;
   cplx_type       unit_in, unit_out;
   op_type         cfg_op, unit_op;

   logic [NW-1:0]  n_eff, ni, mi, pi;
   logic [IW-1:0]  ki, li, ii;
   logic [IW-1:0]  p_row, p_col, q_row, q_col;
   logic [ADW-1:0] p_addr, q_addr, item_addr;
   logic           item_out_of_range;

   function automatic logic [ADW-1:0] entry_addr(input logic [IW-1:0] r,
                                                 input logic [IW-1:0] c);
      return ADW'(r) + ADW'(c) * ADW'(MAX_ORDER);
   endfunction

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tri_ff   <= 1'b0;
         herm_ff  <= 1'b0;
         skew_ff  <= 1'b0;
         order_ff <= ORDER_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TRIANGLE:  tri_ff   <= csr_wdata[0];
            CSR_HERMITIAN: herm_ff  <= csr_wdata[0];
            CSR_SKEW:      skew_ff  <= csr_wdata[0];
            CSR_ORDER:     order_ff <= csr_wdata[ORD_W-1:0];
         endcase
      end
   end

   // Effective order and symmetry operation
   assign n_eff  = (NW'(order_ff) > MAX_N) ? MAX_N : NW'(order_ff);
   assign cfg_op = op_type'({herm_ff, skew_ff});

   // Entry positions of the current pair
   assign ki = k0_ff[IW-1:0];
   assign li = l0_ff[IW-1:0];
   assign ii = i_ff[IW-1:0];

   always_comb begin
      p_row = ki;
      p_col = ki;
      q_row = li;
      q_col = li;
      unique case (phase_ff)
         PH_DIAG: begin
            p_row = ki; p_col = ki; q_row = li; q_col = li;
         end
         PH_PRE: begin
            if (tri_ff) begin
               p_row = ii; p_col = ki; q_row = ii; q_col = li;
            end else begin
               p_row = ki; p_col = ii; q_row = li; q_col = ii;
            end
         end
         PH_KL: begin
            if (tri_ff) begin
               p_row = ki; p_col = li; q_row = ki; q_col = li;
            end else begin
               p_row = li; p_col = ki; q_row = li; q_col = ki;
            end
         end
         PH_MID: begin
            if (tri_ff) begin
               p_row = ki; p_col = ii; q_row = ii; q_col = li;
            end else begin
               p_row = ii; p_col = ki; q_row = li; q_col = ii;
            end
         end
         PH_POST: begin
            if (tri_ff) begin
               p_row = ki; p_col = ii; q_row = li; q_col = ii;
            end else begin
               p_row = ii; p_col = ki; q_row = ii; q_col = li;
            end
         end
         default: begin
            p_row = ki; p_col = ki; q_row = li; q_col = li;
         end
      endcase
   end

   assign p_addr    = entry_addr(p_row, p_col);
   assign q_addr    = entry_addr(q_row, q_col);
   assign item_addr = entry_addr(IW'(row_ff), IW'(col_ff));
   assign item_out_of_range = (NW'(row_ff) >= MAX_N) || (NW'(col_ff) >= MAX_N);

   // Shared operation unit: q data on the first write, held p data on the second
   assign unit_op = (phase_ff == PH_KL || phase_ff == PH_MID) ? cfg_op : OP_IDENT;
   assign unit_in = (state_ff == S_WR_Q) ? hold_ff : ram_rdata;

   tsi_op_unit u_op_unit (
      .op       (unit_op),
      .data_in  (unit_in),
      .data_out (unit_out)
   );

   tsi_ram #(
      .WIDTH ($bits(cplx_type)),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Loop steps
   assign ni = i_ff + ONE_N;
   assign mi = k0_ff + ONE_N;
   assign pi = l0_ff + ONE_N;

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      func_in       = func_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      val_in        = val_ff;
      k_in          = k_ff;
      l_in          = l_ff;
      k0_in         = k0_ff;
      l0_in         = l0_ff;
      i_in          = i_ff;
      hold_in       = hold_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = p_addr;
      ram_raddr     = p_addr;
      ram_wdata     = unit_out;

      // response taken by the receiver
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               row_in   = req_tdata[5:0];
               col_in   = req_tdata[11:6];
               val_in   = '{im: req_tdata[75:44], re: req_tdata[43:12]};
               k_in     = req_tdata[82:76];
               l_in     = req_tdata[89:83];
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_in    = '0;
            status_in = 1'b0;
            state_in  = S_RESP;
            unique case (func_ff)
               FUNC_WRITE: begin
                  if (item_out_of_range) begin
                     status_in = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = item_addr;
                     ram_wdata = val_ff;
                  end
               end
               FUNC_READ: begin
                  if (item_out_of_range) begin
                     status_in = 1'b1;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = item_addr;
                     state_in  = S_RD_WAIT;
                  end
               end
               FUNC_SWAP: begin
                  priority if (n_eff == '0 || k_ff == '0 || k_ff == l_ff) begin
                     status_in = 1'b0;
                  end else if (k_ff > l_ff || NW'(l_ff) > n_eff) begin
                     status_in = 1'b1;
                  end else begin
                     k0_in    = NW'(k_ff) - ONE_N;
                     l0_in    = NW'(l_ff) - ONE_N;
                     i_in     = '0;
                     phase_in = PH_DIAG;
                     state_in = S_RD_P;
                  end
               end
               default: begin
                  status_in = 1'b1;
               end
            endcase
         end

         S_RD_WAIT: begin
            res_in   = ram_rdata;
            state_in = S_RESP;
         end

         S_RD_P: begin
            ram_re    = 1'b1;
            ram_raddr = p_addr;
            state_in  = S_RD_Q;
         end

         S_RD_Q: begin
            ram_re    = 1'b1;
            ram_raddr = q_addr;
            hold_in   = ram_rdata;
            state_in  = S_WR_P;
         end

         S_WR_P: begin
            ram_we    = 1'b1;
            ram_waddr = p_addr;
            ram_wdata = unit_out;
            state_in  = S_WR_Q;
         end

         S_WR_Q: begin
            ram_we    = 1'b1;
            ram_waddr = q_addr;
            ram_wdata = unit_out;
            state_in  = S_RD_P;
            // step to the next pair, skipping empty segments
            unique case (phase_ff)
               PH_DIAG: begin
                  i_in     = '0;
                  phase_in = (k0_ff != '0) ? PH_PRE : PH_KL;
               end
               PH_PRE: begin
                  if (ni < k0_ff) begin
                     i_in = ni;
                  end else begin
                     phase_in = PH_KL;
                  end
               end
               PH_KL, PH_MID: begin
                  priority if (phase_ff == PH_KL && mi < l0_ff) begin
                     i_in     = mi;
                     phase_in = PH_MID;
                  end else if (phase_ff == PH_MID && ni < l0_ff) begin
                     i_in = ni;
                  end else if (pi < n_eff) begin
                     i_in     = pi;
                     phase_in = PH_POST;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               PH_POST: begin
                  if (ni < n_eff) begin
                     i_in = ni;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff      <= phase_in;
      func_ff       <= func_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      val_ff        <= val_in;
      k_ff          <= k_in;
      l_ff          <= l_in;
      k0_ff         <= k0_in;
      l0_ff         <= l0_in;
      i_ff          <= i_in;
      hold_ff       <= hold_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Checks on the sequencer
   `TSI_ASSERT_NOW(a_we_state, ram_we, (state_ff == S_DECODE || state_ff == S_WR_P || state_ff == S_WR_Q), "RAM written outside a write step")
   `TSI_ASSERT_NOW(a_pre_bound, (state_ff == S_RD_P && phase_ff == PH_PRE), (i_ff < k0_ff), "leading segment index past k")
   `TSI_ASSERT_NOW(a_mid_bound, (state_ff == S_RD_P && phase_ff == PH_MID), (i_ff > k0_ff && i_ff < l0_ff), "middle segment index outside k..l")
   `TSI_ASSERT_NOW(a_post_bound, (state_ff == S_RD_P && phase_ff == PH_POST), (i_ff < n_eff), "trailing segment index past n")
   `TSI_ASSERT_NEXT(a_resp_hold, (state_ff == S_RESP && rsp_valid_ff && !rsp_tready), (state_ff == S_RESP), "response dropped over a pending one")

endmodule

`default_nettype wire

/* test/tb_triangular_symmetric_interchange.sv */
// Self-checking testbench for the triangle-stored matrix interchange block.
// Drives requests from a queue, predicts each response and checks every field.
// Depends on tsi_pkg and the triangular_symmetric_interchange RTL.
`timescale 1ns / 1ps

module tb_triangular_symmetric_interchange;
   import tsi_pkg::*;

   localparam int ORDER_MAX   = 64;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   // Function code the block does not know
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

   // One request as the host sees it
   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [VAL_W-1:0]  vre;
      logic [VAL_W-1:0]  vim;
      logic [ORD_W-1:0]  k;
      logic [ORD_W-1:0]  l;
   } matrix_req_type;

   // One response
   typedef struct {
      logic [VAL_W-1:0] re;
      logic [VAL_W-1:0] im;
      logic             status;
   } entry_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_TRIANGLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   triangular_symmetric_interchange #(
      .MAX_ORDER(ORDER_MAX)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Mirror of the configuration registers
   logic             cfg_tri   = 1'b0;
   logic             cfg_herm  = 1'b0;
   logic             cfg_skew  = 1'b0;
   logic [ORD_W-1:0] cfg_order = ORDER_RESET;

   // Predicted matrix contents, column-major
   cplx_type store_img [0:ORDER_MAX*ORDER_MAX-1];
   // Entries the stimulus has written so far
   bit       loaded    [0:ORDER_MAX*ORDER_MAX-1];

   matrix_req_type pending_reqs[$];
   entry_rsp_type  expected_rsps[$];
   matrix_req_type drv_item;

   int error_count = 0;
   int cycle_count = 0;
   int drv_gap     = 0;
   int rcv_wait    = 0;
   int rsp_count   = 0;
   bit idle_off    = 1'b0;

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------
   function automatic int loc(int r, int c);
      return r + c * ORDER_MAX;
   endfunction

   function automatic int order_eff();
      return (cfg_order > ORDER_MAX) ? ORDER_MAX : int'(cfg_order);
   endfunction

   function automatic logic [VAL_W-1:0] neg_sat(logic [VAL_W-1:0] v);
      return (v == VAL_MIN) ? VAL_MAX : -v;
   endfunction

   function automatic cplx_type apply_op(cplx_type v, op_type op);
      cplx_type o;
      o = v;
      case (op)
         OP_NEG: begin
            o.re = neg_sat(v.re);
            o.im = neg_sat(v.im);
         end
         OP_CONJ:   o.im = neg_sat(v.im);
         OP_NEG_RE: o.re = neg_sat(v.re);
         default: ;
      endcase
      return o;
   endfunction

   function automatic void swap_plain(int p, int q);
      cplx_type t;
      t = store_img[p];
      store_img[p] = store_img[q];
      store_img[q] = t;
   endfunction

   function automatic void swap_op(int p, int q, op_type op);
      cplx_type t;
      t = apply_op(store_img[p], op);
      store_img[p] = apply_op(store_img[q], op);
      store_img[q] = t;
   endfunction

   // Interchange rows and columns k and l; returns the status bit
   function automatic logic do_interchange(logic [ORD_W-1:0] k, logic [ORD_W-1:0] l);
      int n, k0, l0, i;
      op_type op;
      n = order_eff();
      if (n == 0 || k == 0 || k == l) return 1'b0;
      if (k > l || l > n) return 1'b1;
      k0 = k - 1;
      l0 = l - 1;
      op = op_type'({cfg_herm, cfg_skew});
      swap_plain(loc(k0, k0), loc(l0, l0));
      // segment before k
      for (i = 0; i < k0; i++) begin
         if (cfg_tri) swap_plain(loc(i, k0), loc(i, l0));
         else swap_plain(loc(k0, i), loc(l0, i));
      end
      // k,l entry and the segment between
      if (cfg_tri) begin
         store_img[loc(k0, l0)] = apply_op(store_img[loc(k0, l0)], op);
         for (i = k0 + 1; i < l0; i++) swap_op(loc(k0, i), loc(i, l0), op);
      end else begin
         store_img[loc(l0, k0)] = apply_op(store_img[loc(l0, k0)], op);
         for (i = k0 + 1; i < l0; i++) swap_op(loc(i, k0), loc(l0, i), op);
      end
      // segment after l
      for (i = l0 + 1; i < n; i++) begin
         if (cfg_tri) swap_plain(loc(k0, i), loc(l0, i));
         else swap_plain(loc(i, k0), loc(i, l0));
      end
      return 1'b0;
   endfunction

   function automatic entry_rsp_type predict_response(matrix_req_type it);
      entry_rsp_type r;
      r.re = '0;
      r.im = '0;
      r.status = 1'b0;
      case (it.func)
         FUNC_WRITE: begin
            store_img[loc(int'(it.row), int'(it.col))].re = it.vre;
            store_img[loc(int'(it.row), int'(it.col))].im = it.vim;
         end
         FUNC_READ: begin
            r.re = store_img[loc(int'(it.row), int'(it.col))].re;
            r.im = store_img[loc(int'(it.row), int'(it.col))].im;
         end
         FUNC_SWAP: r.status = do_interchange(it.k, it.l);
         default:   r.status = 1'b1;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (idle_off) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random value, biased towards the saturation corners
   function automatic logic [VAL_W-1:0] rand_val();
      case ($urandom_range(0, 9))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return '0;
         3: return '1;
         4: return VAL_MIN + 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic matrix_req_type rand_item();
      matrix_req_type it;
      it.func = FUNC_W'($urandom_range(0, 3));
      it.row  = IDX_W'($urandom);
      it.col  = IDX_W'($urandom);
      it.vre  = rand_val();
      it.vim  = rand_val();
      it.k    = ORD_W'($urandom);
      it.l    = ORD_W'($urandom);
      return it;
   endfunction

   task automatic queue_write(int r, int c, logic [VAL_W-1:0] re, logic [VAL_W-1:0] im);
      matrix_req_type it;
      it = rand_item();
      it.func = FUNC_WRITE;
      it.row  = IDX_W'(r);
      it.col  = IDX_W'(c);
      it.vre  = re;
      it.vim  = im;
      loaded[loc(r, c)] = 1'b1;
      pending_reqs.push_back(it);
   endtask

   task automatic ensure_entry(int r, int c);
      if (!loaded[loc(r, c)]) queue_write(r, c, rand_val(), rand_val());
   endtask

   // Position of pair (a,b) inside the stored triangle
   task automatic stored_pos(input int a, input int b, output int r, output int c);
      int lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      r = cfg_tri ? lo : hi;
      c = cfg_tri ? hi : lo;
   endtask

   task automatic queue_read(int r, int c);
      matrix_req_type it;
      ensure_entry(r, c);
      it = rand_item();
      it.func = FUNC_READ;
      it.row  = IDX_W'(r);
      it.col  = IDX_W'(c);
      pending_reqs.push_back(it);
   endtask

   // An interchange that moves data touches the stored entries of rows k and l
   task automatic queue_swap(int k, int l);
      matrix_req_type it;
      int n, i, r, c;
      n = order_eff();
      if (n != 0 && k != 0 && k < l && l <= n) begin
         for (i = 0; i < n; i++) begin
            stored_pos(i, k - 1, r, c);
            ensure_entry(r, c);
            stored_pos(i, l - 1, r, c);
            ensure_entry(r, c);
         end
      end
      it = rand_item();
      it.func = FUNC_SWAP;
      it.k    = ORD_W'(k);
      it.l    = ORD_W'(l);
      pending_reqs.push_back(it);
   endtask

   // Unknown function code with random fields
   task automatic queue_bad_func();
      matrix_req_type it;
      it = rand_item();
      it.func = FUNC_UNKNOWN;
      pending_reqs.push_back(it);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] a, logic [CSR_DATA_W-1:0] d);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      case (a)
         CSR_TRIANGLE:  cfg_tri   = d[0];
         CSR_HERMITIAN: cfg_herm  = d[0];
         CSR_SKEW:      cfg_skew  = d[0];
         CSR_ORDER:     cfg_order = d[ORD_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold the sender until every response is back, then let the block settle;
   // sampled between edges so that a request popped at an edge is seen
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(logic t, logic h, logic s, logic [ORD_W-1:0] n);
      wait_drained();
      write_reg(CSR_TRIANGLE, CSR_DATA_W'(t));
      write_reg(CSR_HERMITIAN, CSR_DATA_W'(h));
      write_reg(CSR_SKEW, CSR_DATA_W'(s));
      write_reg(CSR_ORDER, CSR_DATA_W'(n));
   endtask

   // Random mix of mostly well-formed requests for the current setting
   task automatic random_phase(int count);
      int j, r, n, k, l, a, b, pr, pc;
      n = order_eff();
      for (j = 0; j < count; j++) begin
         r = $urandom_range(0, 99);
         if (n > 0 && $urandom_range(0, 9) < 7) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            stored_pos(a, b, pr, pc);
         end else begin
            pr = $urandom_range(0, ORDER_MAX - 1);
            pc = $urandom_range(0, ORDER_MAX - 1);
         end
         if (r < 35 && n >= 2) begin
            k = $urandom_range(1, n - 1);
            l = $urandom_range(k + 1, n);
            queue_swap(k, l);
         end else if (r < 55) begin
            queue_read(pr, pc);
         end else if (r < 78) begin
            queue_write(pr, pc, rand_val(), rand_val());
         end else if (r < 87) begin
            // interchange that changes nothing
            if ($urandom_range(0, 1)) begin
               queue_swap(0, $urandom_range(0, 127));
            end else begin
               k = $urandom_range(0, 127);
               queue_swap(k, k);
            end
         end else if (r < 96) begin
            // indices out of order or out of range
            if ($urandom_range(0, 1)) begin
               k = $urandom_range(2, 127);
               queue_swap(k, $urandom_range(1, k - 1));
            end else begin
               l = $urandom_range(n + 1, 127);
               queue_swap($urandom_range(1, l), l);
            end
         end else begin
            queue_bad_func();
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      matrix_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         drv_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(predict_response(drv_item));
         if (!req_tvalid || req_tready) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               nxt = pending_reqs.pop_front();
               drv_item   <= nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, nxt.l, nxt.k, nxt.vim, nxt.vre, nxt.col, nxt.row};
               req_tuser  <= nxt.func;
               drv_gap = pick_gap();
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor and receiver back-pressure
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      entry_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rcv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: tdata %h status %b",
                      rsp_tdata, rsp_tuser[0]);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tdata[31:0] !== want.re) begin
                  $error("read_real: expected %h, got %h", want.re, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[63:32] !== want.im) begin
                  $error("read_imag: expected %h, got %h", want.im, rsp_tdata[63:32]);
                  error_count++;
               end
               if (rsp_tuser[0] !== want.status) begin
                  $error("status: expected %b, got %b", want.status, rsp_tuser[0]);
                  error_count++;
               end
            end
            // now and then a long hold-off so the block backs up
            if (rsp_count % 400 == 60) rcv_wait = 500;
            else rcv_wait = pick_gap();
         end else if (rcv_wait > 0) begin
            rcv_wait--;
         end
         rsp_tready <= (rcv_wait == 0);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      int orders [18];
      int ph, i, j;
      orders = '{2, 3, 4, 5, 6, 8, 3, 2, 7, 4, 127, 64, 100, 1, 5, 16, 0, 6};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Order zero: every interchange changes nothing
      set_config(1'b0, 1'b0, 1'b0, 7'd0);
      queue_swap(1, 2);
      queue_swap(5, 3);

      // Lower triangle, skew symmetry, order 4
      set_config(1'b0, 1'b0, 1'b1, 7'd4);
      queue_write(63, 63, VAL_MAX, VAL_MAX);
      queue_write(0, 63, '1, VAL_MIN);
      for (i = 0; i < 4; i++)
         for (j = 0; j <= i; j++)
            queue_write(i, j, ((i + j) % 2) ? VAL_MIN : VAL_MAX, VAL_MIN);
      // changes nothing first, then rejected indices, then a real interchange of 1 and 4
      queue_swap(0, 3);
      queue_swap(2, 2);
      queue_swap(127, 127);
      queue_swap(3, 1);
      queue_swap(2, 5);
      queue_swap(1, 4);
      queue_read(3, 0);
      queue_read(63, 63);
      queue_read(0, 63);
      queue_bad_func();

      // Sweep every mode combination over a range of orders
      for (ph = 0; ph < 18; ph++) begin
         set_config(ph[0], ph[1], ph[2], ORD_W'(orders[ph]));
         idle_off = ($urandom_range(0, 3) == 0);
         random_phase((orders[ph] >= 16) ? 6 : 55);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/tsi_pkg.sv
rtl/tsi_ram.sv
rtl/tsi_op_unit.sv
rtl/triangular_symmetric_interchange.sv
test/tb_triangular_symmetric_interchange.sv
